>>> hdl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int OFF_W       = 23;
  localparam int SIZE_W      = 16;
  localparam int MAX_BLOCKS  = 256;
  localparam int RST_COUNT   = 256;

  localparam logic [15:0] RST_REQ_SIZE = 16'd8;
  localparam logic [3:0]  RST_ALIGN    = 4'd3;
  localparam logic [8:0]  RST_BLOCKS   = 9'd256;

  localparam logic [SIZE_W-1:0] MIN_SIZE  = 16'd8;
  localparam logic [SIZE_W-1:0] MAX_SIZE  = 16'd32768;
  localparam logic [3:0]        MAX_ALIGN = 4'd12;

  // Input command codes.
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REBUILD = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_REQ_SIZE = 2'd0;
  localparam logic [1:0] REG_ALIGN    = 2'd1;
  localparam logic [1:0] REG_BLOCKS   = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_MISALIGN = 2'd3
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [OFF_W-1:0] offset;
  } item_t;

  typedef struct packed {
    logic [OFF_W-1:0] alloc_offset;
    status_t          status;
  } res_t;

endpackage

>>> hdl/fbpa_fifo.sv
// ----------------------------------------------------------------------------
// fbpa_fifo
// Two-entry synchronous queue used between the allocator's stages.
// ----------------------------------------------------------------------------
module fbpa_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      if (do_wr && !do_rd) count <= count + 2'd1;
      else if (do_rd && !do_wr) count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slot[wr_ptr] <= wr_data;
  end

endmodule

>>> hdl/fbpa_cfg.sv
// ----------------------------------------------------------------------------
// fbpa_cfg
// Configuration registers on the APB-style port, and the effective block
// size and block count derived from them.
// ----------------------------------------------------------------------------
module fbpa_cfg #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS,
  localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [fbpa_pkg::SIZE_W-1:0] eff_size,
  output logic [CW-1:0]               eff_count
);

  logic [15:0] requested_block_size;
  logic [3:0]  align_log2;
  logic [8:0]  blocks_in_use;

  logic [1:0]                  reg_idx;
  logic                        wr_en;
  logic [fbpa_pkg::SIZE_W-1:0] req_clamped;
  logic [3:0]                  align_clamped;
  logic [fbpa_pkg::SIZE_W-1:0] mask;
  logic [fbpa_pkg::SIZE_W:0]   rounded;
  logic [31:0]                 count32;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_block_size <= fbpa_pkg::RST_REQ_SIZE;
      align_log2           <= fbpa_pkg::RST_ALIGN;
      blocks_in_use        <= fbpa_pkg::RST_BLOCKS;
    end else if (wr_en) begin
      case (reg_idx)
        fbpa_pkg::REG_REQ_SIZE: requested_block_size <= pwdata[15:0];
        fbpa_pkg::REG_ALIGN:    align_log2           <= pwdata[3:0];
        fbpa_pkg::REG_BLOCKS:   blocks_in_use        <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fbpa_pkg::REG_REQ_SIZE: prdata = {16'd0, requested_block_size};
      fbpa_pkg::REG_ALIGN:    prdata = {28'd0, align_log2};
      fbpa_pkg::REG_BLOCKS:   prdata = {23'd0, blocks_in_use};
      default:                prdata = 32'd0;
    endcase
  end

  // Clamp the requested size and round it up to the alignment. The largest
  // alignment divides the largest size, so the result always fits 16 bits.
  always_comb begin
    if (requested_block_size < fbpa_pkg::MIN_SIZE) req_clamped = fbpa_pkg::MIN_SIZE;
    else if (requested_block_size > fbpa_pkg::MAX_SIZE) req_clamped = fbpa_pkg::MAX_SIZE;
    else req_clamped = requested_block_size;
    align_clamped = (align_log2 > fbpa_pkg::MAX_ALIGN) ? fbpa_pkg::MAX_ALIGN : align_log2;
    mask     = (fbpa_pkg::SIZE_W'(1) << align_clamped) - fbpa_pkg::SIZE_W'(1);
    rounded  = ({1'b0, req_clamped} + {1'b0, mask}) & ~{1'b0, mask};
    eff_size = rounded[fbpa_pkg::SIZE_W-1:0];
    count32  = (32'(blocks_in_use) > 32'(MAX_BLOCKS)) ? 32'(MAX_BLOCKS)
                                                      : 32'(blocks_in_use);
    eff_count = count32[CW-1:0];
  end

endmodule

>>> hdl/fbpa_front.sv
// ----------------------------------------------------------------------------
// fbpa_front
// Accepts input items, classifies each command into an operation and holds
// the classified items in a short queue for the back end.
// ----------------------------------------------------------------------------
module fbpa_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 cmd,
  input  logic [fbpa_pkg::OFF_W-1:0] free_offset,
  input  logic                       free_is_null,
  input  logic                       q_pop,
  output logic                       q_empty,
  output fbpa_pkg::item_t            q_item
);

  fbpa_pkg::item_t                      item_in;
  logic [$bits(fbpa_pkg::item_t)-1:0]   q_data;

  // A null free and the unused command both end up as a plain no-op.
  always_comb begin
    item_in.offset = free_offset;
    case (cmd)
      fbpa_pkg::CMD_ALLOC:   item_in.op = fbpa_pkg::OP_ALLOC;
      fbpa_pkg::CMD_FREE:    item_in.op = free_is_null ? fbpa_pkg::OP_NOP : fbpa_pkg::OP_FREE;
      fbpa_pkg::CMD_REBUILD: item_in.op = fbpa_pkg::OP_REBUILD;
      default:               item_in.op = fbpa_pkg::OP_NOP;
    endcase
  end

  fbpa_fifo #(
    .W($bits(fbpa_pkg::item_t))
  ) u_item_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (item_in),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  assign q_item = fbpa_pkg::item_t'(q_data);

endmodule

>>> hdl/fbpa_div.sv
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle, for the free offset check.
// ----------------------------------------------------------------------------
module fbpa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fbpa_pkg::OFF_W-1:0]  dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [fbpa_pkg::OFF_W-1:0]  quotient,
  output logic [fbpa_pkg::SIZE_W-1:0] remainder
);

  localparam int STEPS = fbpa_pkg::OFF_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                        busy;
  logic [CNT_W-1:0]            cnt;
  logic [fbpa_pkg::OFF_W-1:0]  dq;
  logic [fbpa_pkg::SIZE_W-1:0] rem;
  logic [fbpa_pkg::SIZE_W-1:0] dvs;
  logic [fbpa_pkg::SIZE_W:0]   trial;
  logic                        fits;
  logic [fbpa_pkg::SIZE_W:0]   diff;

  assign trial     = {rem, dq[fbpa_pkg::OFF_W-1]};
  assign fits      = (trial >= {1'b0, dvs});
  assign diff      = trial - {1'b0, dvs};
  assign quotient  = dq;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      dq  <= {dq[fbpa_pkg::OFF_W-2:0], fits};
      rem <= fits ? diff[fbpa_pkg::SIZE_W-1:0] : trial[fbpa_pkg::SIZE_W-1:0];
    end
  end

endmodule

>>> hdl/fbpa_back.sv
// ----------------------------------------------------------------------------
// fbpa_back
// Carries out classified items: pops and pushes the free list, checks freed
// offsets, and rebuilds the link memory one entry per cycle.
// ----------------------------------------------------------------------------
module fbpa_back #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS,
  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CW = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  fbpa_pkg::item_t             q_item,
  output logic                        q_pop,
  input  logic [fbpa_pkg::SIZE_W-1:0] eff_size,
  input  logic [CW-1:0]               eff_count,
  input  logic                        res_full,
  output logic                        res_wr,
  output fbpa_pkg::res_t              res_data
);

  localparam int PW   = (IW + fbpa_pkg::SIZE_W > fbpa_pkg::OFF_W) ?
                        IW + fbpa_pkg::SIZE_W : fbpa_pkg::OFF_W;
  localparam int EW   = fbpa_pkg::SIZE_W + CW;
  localparam int CMPW = (EW > fbpa_pkg::OFF_W) ? EW : fbpa_pkg::OFF_W;
  localparam int RST_N = (fbpa_pkg::RST_COUNT < MAX_BLOCKS) ? fbpa_pkg::RST_COUNT : MAX_BLOCKS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_RD,
    S_FREE_END,
    S_FREE_CMP,
    S_FREE_DIV,
    S_REBUILD,
    S_DONE
  } state_t;

  state_t                     state;
  logic [IW-1:0]              head;
  logic                       head_valid;
  logic [fbpa_pkg::OFF_W-1:0] cur_off;
  logic [fbpa_pkg::OFF_W-1:0] res_off;
  fbpa_pkg::status_t          res_status;
  logic [EW-1:0]              end_bytes;
  logic [CW-1:0]              reb_idx;
  logic [CW-1:0]              reb_n;
  logic                       reb_cmd;

  // Each entry holds the next index and a bit that is clear at the list end.
  logic [IW:0] link_mem [MAX_BLOCKS];
  logic [IW:0] mem_rdata;
  logic        mem_re;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW:0]   mem_wdata;

  logic                        start;
  logic [PW-1:0]               prod_alloc;
  logic                        div_start;
  logic                        div_done;
  logic [fbpa_pkg::OFF_W-1:0]  div_quo;
  logic [fbpa_pkg::SIZE_W-1:0] div_rem;
  logic                        out_of_range;
  logic                        reb_busy;

  assign start        = (state == S_IDLE) && !q_empty && !res_full;
  assign q_pop        = start;
  assign mem_re       = start && (q_item.op == fbpa_pkg::OP_ALLOC);
  assign prod_alloc   = PW'(head) * PW'(eff_size);
  assign out_of_range = (CMPW'(cur_off) >= CMPW'(end_bytes));
  assign div_start    = (state == S_FREE_CMP) && !out_of_range;
  assign reb_busy     = (state == S_REBUILD) && (reb_idx != reb_n);
  assign res_wr       = (state == S_DONE);
  assign res_data.alloc_offset = res_off;
  assign res_data.status       = res_status;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = reb_idx[IW-1:0];
    mem_wdata = {IW'(reb_idx - CW'(1)), (reb_idx != '0)};
    if (reb_busy) begin
      mem_we = 1'b1;
    end else if (state == S_FREE_DIV && div_done && div_rem == '0) begin
      mem_we    = 1'b1;
      mem_waddr = div_quo[IW-1:0];
      mem_wdata = {head, head_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata <= link_mem[head];
  end

  fbpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (cur_off),
    .divisor   (eff_size),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_REBUILD;
      head_valid <= 1'b0;
      reb_idx    <= '0;
      reb_n      <= CW'(RST_N);
      reb_cmd    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_off    <= q_item.offset;
            res_off    <= '0;
            res_status <= fbpa_pkg::ST_OK;
            case (q_item.op)
              fbpa_pkg::OP_ALLOC: begin
                if (head_valid) begin
                  state <= S_ALLOC_RD;
                end else begin
                  res_status <= fbpa_pkg::ST_EMPTY;
                  state      <= S_DONE;
                end
              end
              fbpa_pkg::OP_FREE: state <= S_FREE_END;
              fbpa_pkg::OP_REBUILD: begin
                reb_idx <= '0;
                reb_n   <= eff_count;
                reb_cmd <= 1'b1;
                state   <= S_REBUILD;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_ALLOC_RD: begin
          res_off    <= prod_alloc[fbpa_pkg::OFF_W-1:0];
          head       <= mem_rdata[IW:1];
          head_valid <= mem_rdata[0];
          state      <= S_DONE;
        end
        S_FREE_END: begin
          end_bytes <= EW'(eff_size) * EW'(eff_count);
          state     <= S_FREE_CMP;
        end
        S_FREE_CMP: begin
          if (out_of_range) begin
            res_status <= fbpa_pkg::ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_FREE_DIV;
          end
        end
        S_FREE_DIV: begin
          if (div_done) begin
            if (div_rem != '0) begin
              res_status <= fbpa_pkg::ST_MISALIGN;
            end else begin
              head       <= div_quo[IW-1:0];
              head_valid <= 1'b1;
            end
            state <= S_DONE;
          end
        end
        S_REBUILD: begin
          if (reb_busy) begin
            reb_idx <= reb_idx + CW'(1);
          end else begin
            head       <= IW'(reb_n - CW'(1));
            head_valid <= (reb_n != '0);
            state      <= reb_cmd ? S_DONE : S_IDLE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Pool of equal-size blocks managed through a LIFO free list of indices.
//
//   Channel   Handshake                Payload
//   input     push / full              cmd, free_offset, free_is_null
//   result    empty / pop              alloc_offset, status
//   config    psel, penable, pwrite    paddr, pwdata, prdata (pready high)
//
// Back end path per item: a no-op or an empty-pool alloc goes straight to
// its result; an alloc reads the link memory once; an out-of-range free stops
// at the end compare; any other free waits on the 23-step remainder divider;
// a rebuild of n blocks takes one link memory write per cycle.
// After reset the back end rebuilds min(256, MAX_BLOCKS) links, one per
// cycle; items are queued but not executed until it is done.
// A two-entry queue on each side lets input and results stall independently.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 cmd,
  input  logic [fbpa_pkg::OFF_W-1:0] free_offset,
  input  logic                       free_is_null,
  output logic                       empty,
  input  logic                       pop,
  output logic [fbpa_pkg::OFF_W-1:0] alloc_offset,
  output logic [1:0]                 status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [3:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);

  logic [fbpa_pkg::SIZE_W-1:0]       eff_size;
  logic [CW-1:0]                     eff_count;
  logic                              q_pop;
  logic                              q_empty;
  fbpa_pkg::item_t                   q_item;
  logic                              res_full;
  logic                              res_wr;
  fbpa_pkg::res_t                    res_in;
  logic [$bits(fbpa_pkg::res_t)-1:0] res_q;
  fbpa_pkg::res_t                    res_out;

  fbpa_cfg #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_size  (eff_size),
    .eff_count (eff_count)
  );

  fbpa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .cmd          (cmd),
    .free_offset  (free_offset),
    .free_is_null (free_is_null),
    .q_pop        (q_pop),
    .q_empty      (q_empty),
    .q_item       (q_item)
  );

  fbpa_back #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .eff_size  (eff_size),
    .eff_count (eff_count),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res_data  (res_in)
  );

  fbpa_fifo #(
    .W($bits(fbpa_pkg::res_t))
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_wr),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_q),
    .empty   (empty)
  );

  assign res_out      = fbpa_pkg::res_t'(res_q);
  assign alloc_offset = res_out.alloc_offset;
  assign status       = res_out.status;

  // The back end only starts an item when its result has room to land.
  a_res_room: assert property (@(posedge clk) disable iff (rst)
    res_wr |-> !res_full)
    else $error("result written while the result queue is full");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("item taken from an empty item queue");

  // Error results carry offset zero, as do all non-alloc items (not asserted).
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != fbpa_pkg::ST_OK) |-> (alloc_offset == '0))
    else $error("error result carries a nonzero offset");

endmodule
